// ----- src/assert_macros.svh -----
// assertion helpers shared by the rtl
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef NO_ASSERTIONS

// check on every rising edge outside reset
`define APD_ASSERT(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// check on every rising edge, reset included
`define APD_ASSERT_ALWAYS(label, clk, prop, msg) \
    label: assert property (@(posedge clk) prop) else $error(msg);

`else

`define APD_ASSERT(label, clk, rst_n, prop, msg)
`define APD_ASSERT_ALWAYS(label, clk, prop, msg)

`endif

`endif

// ----- src/apd_pkg.sv -----
`timescale 1ns / 1ps

package apd_pkg;

    localparam int SAMPLE_W = 16;
    localparam int FORMAT_W = 2;
    localparam int CFG_DATA_W = 16;
    localparam int CFG_INDEX_W = 1;

    // sample format codes
    localparam logic [FORMAT_W-1:0] FMT_8BIT  = 2'd0;
    localparam logic [FORMAT_W-1:0] FMT_16BIT = 2'd1;

    // register indexes
    localparam logic [CFG_INDEX_W-1:0] REG_FORMAT    = 1'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_THRESHOLD = 1'd1;

    localparam logic [FORMAT_W-1:0]   FORMAT_RESET    = FMT_8BIT;
    localparam logic [SAMPLE_W-1:0]   THRESHOLD_RESET = 16'd25;
    localparam logic [SAMPLE_W-1:0]   MIN_RESET       = 16'hFFFF;
    localparam logic [SAMPLE_W-1:0]   MAX_RESET       = 16'h0000;

    typedef enum logic [1:0] {
        STATUS_QUIET      = 2'd0,
        STATUS_AUDIO      = 2'd1,
        STATUS_BAD_FORMAT = 2'd2
    } status_t;

    // control flags that travel with each pipeline slot
    typedef struct packed {
        logic valid;
        logic done;
        logic last;
        logic supported;
    } apd_ctrl_t;

endpackage

// ----- src/apd_accum.sv -----
`timescale 1ns / 1ps
`include "assert_macros.svh"

module apd_accum
    import apd_pkg::*;
#(
    parameter int GROUP_SIZE = 8
)
(
    input  logic                                   clk,
    input  logic                                   rst_n,
    input  logic                                   advance,
    input  logic                                   in_fire,
    input  logic [SAMPLE_W-1:0]                    sample,
    input  logic                                   last_sample,
    input  logic [FORMAT_W-1:0]                    sample_format,
    output apd_ctrl_t                              grp_ctrl,
    output logic [SAMPLE_W+$clog2(GROUP_SIZE)-1:0] grp_sum
);

    localparam int CNT_W = $clog2(GROUP_SIZE);
    localparam int SUM_W = SAMPLE_W + CNT_W;
    localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(GROUP_SIZE - 1);

    logic                 s1_valid_reg;
    logic [SAMPLE_W-1:0]  s1_sample_reg;
    logic                 s1_last_reg;
    logic                 s1_supported_reg;

    logic [CNT_W-1:0]     count_reg;
    logic [CNT_W-1:0]     count_next;
    logic [SUM_W-1:0]     sum_reg;
    logic [SUM_W-1:0]     sum_next;

    apd_ctrl_t            s2_ctrl_reg;
    apd_ctrl_t            s2_ctrl_next;
    logic [SUM_W-1:0]     s2_sum_reg;

    logic [SAMPLE_W-1:0]  masked;
    logic                 supported;
    logic [SUM_W-1:0]     sum_add;
    logic                 group_done;

    // 8-bit mode keeps the low byte only
    assign masked    = (sample_format == FMT_8BIT) ? {8'h00, sample[7:0]} : sample;
    assign supported = (sample_format == FMT_8BIT) || (sample_format == FMT_16BIT);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            s1_valid_reg <= in_fire;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            s1_sample_reg    <= masked;
            s1_last_reg      <= last_sample;
            s1_supported_reg <= supported;
        end
    end

    assign sum_add    = sum_reg + SUM_W'(s1_sample_reg);
    assign group_done = s1_valid_reg && s1_supported_reg && (count_reg == CNT_LAST);

    always_comb
    begin
        count_next = count_reg;
        sum_next   = sum_reg;
        if (s1_valid_reg)
        begin
            if (group_done || s1_last_reg)
            begin
                // group complete or buffer end
                count_next = '0;
                sum_next   = '0;
            end
            else if (s1_supported_reg)
            begin
                count_next = count_reg + 1'b1;
                sum_next   = sum_add;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
            sum_reg   <= '0;
        end
        else if (advance)
        begin
            count_reg <= count_next;
            sum_reg   <= sum_next;
        end
    end

    always_comb
    begin
        s2_ctrl_next.valid     = s1_valid_reg;
        s2_ctrl_next.done      = group_done;
        s2_ctrl_next.last      = s1_last_reg;
        s2_ctrl_next.supported = s1_supported_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s2_ctrl_reg <= '0;
        end
        else if (advance)
        begin
            s2_ctrl_reg <= s2_ctrl_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            s2_sum_reg <= sum_add;
        end
    end

    assign grp_ctrl = s2_ctrl_reg;
    assign grp_sum  = s2_sum_reg;

    `APD_ASSERT(a_count_in_range, clk, rst_n, count_reg <= CNT_LAST, "group count past group size")
    `APD_ASSERT(a_done_clears, clk, rst_n, (advance && group_done) |=> (count_reg == '0 && sum_reg == '0), "accumulator not cleared after full group")

endmodule

// ----- src/apd_divide.sv -----
`timescale 1ns / 1ps

module apd_divide
    import apd_pkg::*;
#(
    parameter int GROUP_SIZE = 8
)
(
    input  logic                                   clk,
    input  logic                                   rst_n,
    input  logic                                   advance,
    input  apd_ctrl_t                              grp_ctrl,
    input  logic [SAMPLE_W+$clog2(GROUP_SIZE)-1:0] grp_sum,
    output apd_ctrl_t                              avg_ctrl,
    output logic [SAMPLE_W-1:0]                    avg
);

    // floor(sum / GROUP_SIZE) as a multiply by a rounded-up reciprocal
    localparam int LOG_G  = $clog2(GROUP_SIZE);
    localparam int SUM_W  = SAMPLE_W + LOG_G;
    localparam int SHIFT  = SUM_W + LOG_G;
    localparam int RECIP_W = SUM_W + 2;
    localparam int PROD_W = SUM_W + RECIP_W;
    localparam logic [RECIP_W-1:0] RECIP =
        RECIP_W'((64'd1 << SHIFT) / GROUP_SIZE + 64'd1);

    logic [PROD_W-1:0]   product;
    apd_ctrl_t           s3_ctrl_reg;
    logic [SAMPLE_W-1:0] s3_avg_reg;

    assign product = PROD_W'(grp_sum) * PROD_W'(RECIP);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s3_ctrl_reg <= '0;
        end
        else if (advance)
        begin
            s3_ctrl_reg <= grp_ctrl;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            s3_avg_reg <= product[SHIFT +: SAMPLE_W];
        end
    end

    assign avg_ctrl = s3_ctrl_reg;
    assign avg      = s3_avg_reg;

endmodule

// ----- src/apd_range.sv -----
`timescale 1ns / 1ps
`include "assert_macros.svh"

module apd_range
    import apd_pkg::*;
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                advance,
    input  apd_ctrl_t           avg_ctrl,
    input  logic [SAMPLE_W-1:0] avg,
    input  logic [SAMPLE_W-1:0] range_threshold,
    output logic                res_fire,
    output status_t             res_status
);

    logic [SAMPLE_W-1:0] min_reg;
    logic [SAMPLE_W-1:0] min_next;
    logic [SAMPLE_W-1:0] max_reg;
    logic [SAMPLE_W-1:0] max_next;
    logic                seen_reg;
    logic                seen_next;

    logic [SAMPLE_W-1:0] upd_min;
    logic [SAMPLE_W-1:0] upd_max;
    logic                upd_seen;
    logic [SAMPLE_W-1:0] spread;

    // fold in the group average that completes here, if any
    always_comb
    begin
        upd_min  = min_reg;
        upd_max  = max_reg;
        upd_seen = seen_reg;
        if (avg_ctrl.done)
        begin
            if (avg < min_reg)
            begin
                upd_min = avg;
            end
            if (avg > max_reg)
            begin
                upd_max = avg;
            end
            upd_seen = 1'b1;
        end
    end

    assign spread = upd_max - upd_min;

    always_comb
    begin
        if (!avg_ctrl.supported)
        begin
            res_status = STATUS_BAD_FORMAT;
        end
        else if (upd_seen && (upd_max >= upd_min) && (spread > range_threshold))
        begin
            res_status = STATUS_AUDIO;
        end
        else
        begin
            res_status = STATUS_QUIET;
        end
    end

    assign res_fire = avg_ctrl.valid && avg_ctrl.last;

    always_comb
    begin
        min_next  = min_reg;
        max_next  = max_reg;
        seen_next = seen_reg;
        if (avg_ctrl.valid)
        begin
            if (avg_ctrl.last)
            begin
                min_next  = MIN_RESET;
                max_next  = MAX_RESET;
                seen_next = 1'b0;
            end
            else
            begin
                min_next  = upd_min;
                max_next  = upd_max;
                seen_next = upd_seen;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            min_reg  <= MIN_RESET;
            max_reg  <= MAX_RESET;
            seen_reg <= 1'b0;
        end
        else if (advance)
        begin
            min_reg  <= min_next;
            max_reg  <= max_next;
            seen_reg <= seen_next;
        end
    end

    `APD_ASSERT(a_seen_ordered, clk, rst_n, seen_reg |-> (min_reg <= max_reg), "min above max after a full group")
    `APD_ASSERT(a_unseen_clear, clk, rst_n, !seen_reg |-> (min_reg == MIN_RESET && max_reg == MAX_RESET), "extremes moved without a full group")
    `APD_ASSERT(a_bad_format, clk, rst_n, (res_fire && !avg_ctrl.supported) |-> (res_status == STATUS_BAD_FORMAT), "unsupported format not reported")

endmodule

// ----- src/audio_presence_detector_unit.sv -----
`timescale 1ns / 1ps

// channel   direction  handshake             payload
// input     in         in_valid / in_stall   sample[15:0], last_sample
// result    out        out_valid / out_stall status[1:0]
// config    in         cfg_write             cfg_index[0], cfg_data[15:0]
//
// one sample is taken per cycle while no result is held up at the output
// a result passes the input register, the accumulator stage and the divide stage to the output register
// the group average costs one multiply by a constant reciprocal, in its own stage
// rst_n clears the pipeline, the accumulator, the extremes and the registers
// out_stall with a result waiting freezes the whole pipeline and raises in_stall

module audio_presence_detector_unit
    import apd_pkg::*;
#(
    parameter int GROUP_SIZE = 8
)
(
    input  logic                   clk,
    input  logic                   rst_n,
    // sample stream
    input  logic                   in_valid,
    output logic                   in_stall,
    input  logic [SAMPLE_W-1:0]    sample,
    input  logic                   last_sample,
    // result stream
    output logic                   out_valid,
    input  logic                   out_stall,
    output logic [1:0]             status,
    // register writes
    input  logic                   cfg_write,
    input  logic [CFG_INDEX_W-1:0] cfg_index,
    input  logic [CFG_DATA_W-1:0]  cfg_data
);

    localparam int SUM_W = SAMPLE_W + $clog2(GROUP_SIZE);

    // configuration registers
    logic [FORMAT_W-1:0] format_reg;
    logic [SAMPLE_W-1:0] threshold_reg;

    // pipeline moves unless a held result is stalled
    logic                advance;
    logic                in_fire;

    apd_ctrl_t           grp_ctrl;
    logic [SUM_W-1:0]    grp_sum;
    apd_ctrl_t           avg_ctrl;
    logic [SAMPLE_W-1:0] avg;
    logic                res_fire;
    status_t             res_status;

    // output register
    logic                out_valid_reg;
    status_t             status_reg;

    assign advance  = !(out_valid_reg && out_stall);
    assign in_stall = !advance;
    assign in_fire  = in_valid && advance;

    // register writes: issue them only while nothing is in flight; the block does not enforce this
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            format_reg    <= FORMAT_RESET;
            threshold_reg <= THRESHOLD_RESET;
        end
        else if (cfg_write)
        begin
            unique case (cfg_index)
                REG_FORMAT:    format_reg    <= cfg_data[FORMAT_W-1:0];
                REG_THRESHOLD: threshold_reg <= cfg_data[SAMPLE_W-1:0];
                default:       ;
            endcase
        end
    end

    // input register and group accumulator
    apd_accum #(
        .GROUP_SIZE (GROUP_SIZE)
    ) u_accum (
        .clk           (clk),
        .rst_n         (rst_n),
        .advance       (advance),
        .in_fire       (in_fire),
        .sample        (sample),
        .last_sample   (last_sample),
        .sample_format (format_reg),
        .grp_ctrl      (grp_ctrl),
        .grp_sum       (grp_sum)
    );

    // sum to group average
    apd_divide #(
        .GROUP_SIZE (GROUP_SIZE)
    ) u_divide (
        .clk      (clk),
        .rst_n    (rst_n),
        .advance  (advance),
        .grp_ctrl (grp_ctrl),
        .grp_sum  (grp_sum),
        .avg_ctrl (avg_ctrl),
        .avg      (avg)
    );

    // running min and max, decision on the last sample
    apd_range u_range (
        .clk             (clk),
        .rst_n           (rst_n),
        .advance         (advance),
        .avg_ctrl        (avg_ctrl),
        .avg             (avg),
        .range_threshold (threshold_reg),
        .res_fire        (res_fire),
        .res_status      (res_status)
    );

    // result register, refilled on the cycle the held result transfers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            out_valid_reg <= res_fire;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            status_reg <= res_status;
        end
    end

    assign out_valid = out_valid_reg;
    assign status    = status_reg;

endmodule

// ----- tb/sv/apd_checker.sv -----
`timescale 1ns / 1ps

module apd_checker
    import apd_pkg::*;
#(
    parameter int GROUP_SIZE = 8
)
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   in_valid,
    input  logic                   in_stall,
    input  logic [SAMPLE_W-1:0]    sample,
    input  logic                   last_sample,
    input  logic                   out_valid,
    input  logic                   out_stall,
    input  logic [1:0]             status,
    input  logic                   cfg_write,
    input  logic [CFG_INDEX_W-1:0] cfg_index,
    input  logic [CFG_DATA_W-1:0]  cfg_data,
    output int                     fail_count,
    output int                     outstanding
);

    localparam int SUM_W = SAMPLE_W + $clog2(GROUP_SIZE);

    // register copies
    logic [FORMAT_W-1:0] fmt;
    logic [SAMPLE_W-1:0] thr;

    // per-buffer level tracking
    int unsigned         grp_n;
    logic [SUM_W-1:0]    grp_sum;
    logic [SAMPLE_W-1:0] lo_avg;
    logic [SAMPLE_W-1:0] hi_avg;
    logic                seen_group;

    status_t pending_status[$];

    task automatic clear_levels();
        grp_n = 0;
        grp_sum = '0;
        lo_avg = MIN_RESET;
        hi_avg = MAX_RESET;
        seen_group = 1'b0;
    endtask

    // folds one sample into the group averages, queues a verdict on the last one
    task automatic absorb_sample(input logic [SAMPLE_W-1:0] value, input logic is_last);
        logic [SAMPLE_W-1:0] s;
        logic [SAMPLE_W-1:0] avg;
        logic                ok_fmt;
        status_t             verdict;
        s = value;
        ok_fmt = (fmt == FMT_8BIT) || (fmt == FMT_16BIT);
        if (ok_fmt)
        begin
            if (fmt == FMT_8BIT)
                s[SAMPLE_W-1:8] = '0;
            grp_sum = grp_sum + s;
            grp_n++;
            if (grp_n >= GROUP_SIZE)
            begin
                avg = SAMPLE_W'(grp_sum / GROUP_SIZE);
                if (avg < lo_avg)
                    lo_avg = avg;
                if (avg > hi_avg)
                    hi_avg = avg;
                seen_group = 1'b1;
                grp_n = 0;
                grp_sum = '0;
            end
        end
        if (is_last)
        begin
            if (!ok_fmt)
                verdict = STATUS_BAD_FORMAT;
            else if (seen_group && hi_avg >= lo_avg && (hi_avg - lo_avg) > thr)
                verdict = STATUS_AUDIO;
            else
                verdict = STATUS_QUIET;
            pending_status.push_back(verdict);
            clear_levels();
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        status_t want;
        if (!rst_n)
        begin
            fmt = FORMAT_RESET;
            thr = THRESHOLD_RESET;
            clear_levels();
            pending_status.delete();
            fail_count <= 0;
            outstanding <= 0;
        end
        else
        begin
            if (cfg_write)
            begin
                if (cfg_index == REG_FORMAT)
                    fmt = cfg_data[FORMAT_W-1:0];
                else if (cfg_index == REG_THRESHOLD)
                    thr = cfg_data;
            end
            if (out_valid && !out_stall)
            begin
                if (pending_status.size() == 0)
                begin
                    $error("status %0d arrived with no result expected", status);
                    fail_count <= fail_count + 1;
                end
                else
                begin
                    want = pending_status.pop_front();
                    if (status !== want)
                    begin
                        $error("status mismatch: expected %0d, actual %0d", want, status);
                        fail_count <= fail_count + 1;
                    end
                end
            end
            if (in_valid && !in_stall)
                absorb_sample(sample, last_sample);
            outstanding <= pending_status.size();
        end
    end

endmodule

// ----- tb/sv/tb_top.sv -----
`timescale 1ns / 1ps

module tb_top;
    import apd_pkg::*;

    localparam int GROUP = 8;
    // pipeline is four stages deep, leave some margin before touching registers
    localparam int SETTLE_CYCLES = 12;
    localparam int CYCLE_LIMIT = 200000;
    localparam int PHASE_ITEMS = 32;
    localparam int NUM_SETTINGS = 8;

    // format codes the block must reject
    localparam logic [FORMAT_W-1:0] FMT_RESERVED_LO = 2'd2;
    localparam logic [FORMAT_W-1:0] FMT_RESERVED_HI = 2'd3;

    logic                   clk = 1'b0;
    logic                   rst_n = 1'b0;
    logic                   in_valid = 1'b0;
    logic                   in_stall;
    logic [SAMPLE_W-1:0]    sample = '0;
    logic                   last_sample = 1'b0;
    logic                   out_valid;
    logic                   out_stall = 1'b0;
    logic [1:0]             status;
    logic                   cfg_write = 1'b0;
    logic [CFG_INDEX_W-1:0] cfg_index = '0;
    logic [CFG_DATA_W-1:0]  cfg_data = '0;

    int fail_count;
    int outstanding;

    // idle rates in percent, changed per regime
    int gap_pct = 0;
    int stall_pct = 0;

    int cycle_count = 0;
    int items_sent = 0;
    logic [FORMAT_W-1:0] cur_format = FORMAT_RESET;

    audio_presence_detector_unit #(
        .GROUP_SIZE (GROUP)
    ) uut (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_stall    (in_stall),
        .sample      (sample),
        .last_sample (last_sample),
        .out_valid   (out_valid),
        .out_stall   (out_stall),
        .status      (status),
        .cfg_write   (cfg_write),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data)
    );

    apd_checker #(
        .GROUP_SIZE (GROUP)
    ) chk (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_stall    (in_stall),
        .sample      (sample),
        .last_sample (last_sample),
        .out_valid   (out_valid),
        .out_stall   (out_stall),
        .status      (status),
        .cfg_write   (cfg_write),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data),
        .fail_count  (fail_count),
        .outstanding (outstanding)
    );

    // 50 MHz clock
    initial
    begin
        forever #10 clk = ~clk;
    end

    // result side back-pressure, redrawn every cycle
    always @(posedge clk)
    begin
        out_stall <= ($urandom_range(0, 99) < stall_pct);
    end

    // watchdog against a hung handshake or a lost result
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("[FAIL] regression broken");
            $finish;
        end
    end

    // one sample transfer, with random idle cycles ahead of it
    task automatic send(input logic [SAMPLE_W-1:0] value, input logic is_last);
        while ($urandom_range(0, 99) < gap_pct)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        sample <= value;
        last_sample <= is_last;
        @(posedge clk);
        // in_stall read here is the value seen at that edge
        while (in_stall)
            @(posedge clk);
        items_sent++;
    endtask

    // hold the sender until every verdict is back and the pipeline has emptied
    task automatic settle();
        in_valid <= 1'b0;
        do
            @(posedge clk);
        while (outstanding != 0);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_reg(input logic [CFG_INDEX_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] value);
        cfg_write <= 1'b1;
        cfg_index <= idx;
        cfg_data <= value;
        @(posedge clk);
        cfg_write <= 1'b0;
    endtask

    // register settings cycled through in each regime, extremes included
    task automatic apply_setting(input int which);
        logic [FORMAT_W-1:0]   f;
        logic [CFG_DATA_W-1:0] t;
        case (which)
            0:
            begin
                f = FMT_8BIT;
                t = '0;
            end
            1:
            begin
                f = FMT_8BIT;
                t = '1;
            end
            2:
            begin
                f = FMT_8BIT;
                t = CFG_DATA_W'($urandom_range(0, 80));
            end
            3:
            begin
                f = FMT_16BIT;
                t = '0;
            end
            4:
            begin
                f = FMT_16BIT;
                t = '1;
            end
            5:
            begin
                f = FMT_16BIT;
                t = CFG_DATA_W'($urandom_range(0, 4000));
            end
            6:
            begin
                f = FMT_RESERVED_LO;
                t = CFG_DATA_W'($urandom);
            end
            default:
            begin
                f = FMT_RESERVED_HI;
                t = CFG_DATA_W'($urandom);
            end
        endcase
        write_reg(REG_FORMAT, CFG_DATA_W'(f));
        write_reg(REG_THRESHOLD, t);
        cur_format = f;
    endtask

    // one buffer: mostly whole groups, some with a ragged tail, some too short
    // for any group; each group sits at its own level with a little jitter
    task automatic send_buffer();
        int shape;
        int n_groups;
        int tail;
        int length;
        int swing;
        int jitter;
        logic [SAMPLE_W-1:0] base;
        logic [SAMPLE_W-1:0] level;
        logic [SAMPLE_W-1:0] value;
        shape = $urandom_range(0, 99);
        n_groups = $urandom_range(1, 6);
        tail = 0;
        if (shape >= 85)
        begin
            n_groups = 0;
            tail = $urandom_range(1, GROUP - 1);
        end
        else if (shape >= 70)
            tail = $urandom_range(1, GROUP - 1);
        length = n_groups * GROUP + tail;
        case ($urandom_range(0, 4))
            0: swing = 0;
            1: swing = 20;
            2: swing = 60;
            3: swing = 3000;
            default: swing = 65535;
        endcase
        jitter = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 40);
        base = SAMPLE_W'($urandom);
        level = base;
        for (int i = 0; i < length; i++)
        begin
            if (i % GROUP == 0)
                level = base + SAMPLE_W'($urandom_range(0, swing));
            value = level + SAMPLE_W'($urandom_range(0, jitter));
            // upper byte is don't-care in 8-bit mode, keep it noisy
            if (cur_format == FMT_8BIT)
                value[SAMPLE_W-1:8] = 8'($urandom);
            send(value, i == length - 1);
        end
    endtask

    initial
    begin
        int phase_start;
        gap_pct = 34;
        stall_pct = 61;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // reset settings: 8-bit samples, threshold 25
        // lone last sample, no full group so quiet
        send(16'h1234, 1'b1);
        // one group closed by the last sample, single average so zero range;
        // upper byte set but masked
        repeat (GROUP - 1) send(16'hFFFF, 1'b0);
        send(16'hFFFF, 1'b1);
        settle();

        // unsupported format reports bad format and clears
        write_reg(REG_FORMAT, CFG_DATA_W'(FMT_RESERVED_LO));
        send(16'h0000, 1'b0);
        send(16'hFFFF, 1'b1);
        settle();

        // format switch in the middle of a buffer: first group at full 16-bit
        // scale, second group masked down to 8 bits
        write_reg(REG_FORMAT, CFG_DATA_W'(FMT_16BIT));
        write_reg(REG_THRESHOLD, 16'd0);
        cur_format = FMT_16BIT;
        repeat (GROUP) send(16'hFFFF, 1'b0);
        settle();
        write_reg(REG_FORMAT, CFG_DATA_W'(FMT_8BIT));
        cur_format = FMT_8BIT;
        repeat (GROUP - 1) send(16'hFFFF, 1'b0);
        send(16'hFFFF, 1'b1);

        // random buffers: three idle regimes, every register setting in each
        for (int regime = 0; regime < 3; regime++)
        begin
            settle();
            case (regime)
                0:
                begin
                    gap_pct = 34;
                    stall_pct = 61;
                end
                1:
                begin
                    gap_pct = 61;
                    stall_pct = 34;
                end
                default:
                begin
                    gap_pct = 0;
                    stall_pct = 0;
                end
            endcase
            for (int which = 0; which < NUM_SETTINGS; which++)
            begin
                settle();
                apply_setting(which);
                phase_start = items_sent;
                while (items_sent - phase_start < PHASE_ITEMS)
                begin
                    send_buffer();
                    // now and then let the result side catch up completely
                    if ($urandom_range(0, 5) == 0)
                        settle();
                end
            end
        end

        settle();
        if (fail_count == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

endmodule
